[hw/rtl/tpsu_pkg.sv]
// tpsu_pkg: types, constants and step functions of the touch panel scan unit
// used by every module of the block, depends on nothing

package tpsu_pkg;

    localparam int PANEL_WIDTH  = 240;
    localparam int PANEL_HEIGHT = 359;
    localparam int TICK_US      = 10;

    localparam logic [15:0] YP_BASE = 16'h81E1;
    localparam logic [15:0] YM_BASE = 16'h8E30;
    localparam logic [15:0] XM_BASE = 16'h8D1B;
    localparam logic [15:0] XP_BASE = 16'h8300;
    localparam int Y_SPAN = 16'h8E30 - 16'h81E1;
    localparam int X_SPAN = 16'h8D1B - 16'h8300;

    localparam int COORD_W   = 10;
    localparam int PROD_W    = 22;
    localparam int REC_W     = 33;
    localparam int REC_SHIFT = 32;
    localparam int QUOT_W    = 12;
    localparam logic [REC_W-1:0] REC_Y =
        REC_W'(((64'd1 << REC_SHIFT) + 64'(PANEL_HEIGHT) - 64'd1) / 64'(PANEL_HEIGHT));
    localparam logic [REC_W-1:0] REC_X =
        REC_W'(((64'd1 << REC_SHIFT) + 64'(PANEL_WIDTH - 1) - 64'd1) / 64'(PANEL_WIDTH - 1));
    localparam logic [COORD_W-1:0] X_MAX = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(PANEL_HEIGHT - 1);

    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] UNIT_MUL = CNT_W'(30 / TICK_US);
    localparam logic [CNT_W-1:0] CONV4    = CNT_W'(40 / TICK_US);
    localparam logic [CNT_W-1:0] CONV5    = CNT_W'(50 / TICK_US);

    localparam logic [7:0] PEND_COORD = 8'h1C;
    localparam logic [7:0] PEND_LOST  = 8'h04;
    localparam logic [7:0] PEND_ANY   = 8'h5D;
    localparam logic [9:0] CTRL_WMASK = 10'h3FE;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_INTR   = 3'd1;
    localparam logic [2:0] REG_SCAN   = 3'd2;
    localparam logic [2:0] REG_SETTLE = 3'd3;

    localparam logic [2:0] SS_OFF     = 3'd0;
    localparam logic [2:0] SS_STANDBY = 3'd1;
    localparam logic [2:0] SS_WAIT    = 3'd4;
    localparam logic [2:0] SS_SETTLE  = 3'd5;
    localparam logic [2:0] SS_SCAN    = 3'd6;

    localparam int ROW_W = 64;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_IDLE  = 2'd3
    } func_t;

    typedef enum logic {
        RK_WORD = 1'b0,
        RK_PAGE = 1'b1
    } rd_kind_t;

    typedef struct packed {
        logic [9:0]       cw;
        logic [15:0]      iw;
        logic [15:0]      siw;
        logic [15:0]      stw;
        logic [2:0]       ss;
        logic             prev;
        logic             lat;
        logic             qc;
        logic             qs;
        logic             armed;
        logic [CNT_W-1:0] cnt;
        logic             np;
        logic [1:0]       pv;
        logic             smp;
        logic             smp_pg;
    } st_t;

    typedef struct packed {
        rd_kind_t          kind;
        logic [15:0]       word;
        logic [1:0]        k;
        logic              pg;
        logic              irq;
        logic              wr_en;
        logic              wr_pg;
        logic [PROD_W-1:0] ny;
        logic [PROD_W-1:0] nx;
    } s1_t;

    function automatic logic [CNT_W-1:0] conv_units(st_t s);
        return CNT_W'(CNT_W'(s.stw[5:0]) * UNIT_MUL) + (s.cw[5] ? CONV5 : CONV4);
    endfunction

    function automatic logic [CNT_W-1:0] interval_units(st_t s);
        return CNT_W'(CNT_W'(s.siw[10:0]) * UNIT_MUL) + conv_units(s);
    endfunction

    function automatic logic wait_en(st_t s);
        return s.cw[2] && s.cw[8] && (s.cw[4:3] == 2'd0);
    endfunction

    function automatic st_t clear_coord(st_t s);
        st_t r;
        r = s;
        r.iw[4:2] = 3'd0;
        r.pv = 2'b00;
        r.armed = 1'b0;
        r.cnt = '0;
        r.np = 1'b0;
        return r;
    endfunction

    function automatic st_t raise_change(st_t s, logic down);
        st_t r;
        r = s;
        if (r.iw[0])
        begin
            r.qc = 1'b1;
            r.qs = down;
        end
        else
        begin
            r.lat = down;
            r.iw[0] = 1'b1;
        end
        return r;
    endfunction

    function automatic st_t pen_went_down(st_t s);
        st_t r;
        r = clear_coord(s);
        if (r.ss == SS_WAIT && r.cw[8])
        begin
            r.ss = SS_SETTLE;
            r.armed = 1'b1;
            r.cnt = conv_units(r);
        end
        return raise_change(r, 1'b1);
    endfunction

    function automatic st_t pen_went_up(st_t s);
        st_t r;
        logic w;
        logic sig;
        r = s;
        w = wait_en(r);
        sig = w || (r.ss >= SS_WAIT);
        r.armed = 1'b0;
        r.cnt = '0;
        if (w)
            r.ss = SS_WAIT;
        else if (r.ss > SS_STANDBY)
            r.ss = SS_STANDBY;
        if (sig)
            r = raise_change(r, 1'b0);
        return r;
    endfunction

    function automatic logic page_free(st_t s, logic p);
        return !(p ? s.iw[4] : s.iw[3]) && !s.pv[p];
    endfunction

    function automatic st_t take_sample(st_t s, logic down);
        st_t r;
        logic p;
        r = s;
        p = r.np;
        if (down && r.ss >= SS_SETTLE && r.armed && r.cnt == '0)
        begin
            if (!page_free(r, p))
                p = ~p;
            if (!page_free(r, p))
            begin
                r.iw[2] = 1'b1;
                r.ss = SS_STANDBY;
                r.armed = 1'b0;
                r.cnt = '0;
            end
            else
            begin
                r.pv[p] = 1'b1;
                r.np = ~p;
                if (p)
                    r.iw[4] = 1'b1;
                else
                    r.iw[3] = 1'b1;
                r.ss = SS_SCAN;
                r.armed = 1'b1;
                r.cnt = interval_units(r);
                r.smp = 1'b1;
                r.smp_pg = p;
            end
        end
        return r;
    endfunction

    function automatic st_t control_written(st_t s, logic down);
        st_t r;
        r = s;
        if (r.ss == SS_OFF && r.cw != '0)
            r.ss = SS_STANDBY;
        if (wait_en(r))
        begin
            if (r.ss < SS_WAIT)
                r.ss = SS_WAIT;
            if (down && r.ss == SS_WAIT)
                r = pen_went_down(r);
        end
        else if (!r.cw[2])
        begin
            if (r.ss > SS_STANDBY)
            begin
                r = clear_coord(r);
                r.ss = SS_STANDBY;
            end
        end
        return r;
    endfunction

    function automatic st_t interrupt_written(st_t s, logic [15:0] val, logic down);
        st_t r;
        logic [7:0] ack;
        logic coord_ack;
        logic lost_ack;
        r = s;
        ack = val[7:0];
        coord_ack = |(s.iw[7:0] & ack & PEND_COORD);
        lost_ack = |(s.iw[7:0] & ack & PEND_LOST);
        r.iw[7:0] = r.iw[7:0] & ~(ack & PEND_ANY);
        r.iw[15:8] = val[15:8];
        if (ack[3])
            r.pv[0] = 1'b0;
        if (ack[4])
            r.pv[1] = 1'b0;
        if (ack[0])
        begin
            if (r.qc)
            begin
                r.lat = r.qs;
                r.qc = 1'b0;
                r.iw[0] = 1'b1;
            end
            else
                r.lat = down;
        end
        if (lost_ack && down && wait_en(r) && r.iw[4:2] == 3'd0)
        begin
            r.ss = SS_SETTLE;
            r.armed = 1'b1;
            r.cnt = conv_units(r);
        end
        if (coord_ack && down && r.ss >= SS_SETTLE && !r.armed)
        begin
            r.armed = 1'b1;
            r.cnt = interval_units(r);
        end
        return r;
    endfunction

    function automatic logic [15:0] page_default(logic [1:0] k);
        logic [15:0] w;
        case (k)
            2'd0:    w = YP_BASE;
            2'd1:    w = YM_BASE;
            2'd2:    w = XP_BASE;
            default: w = XM_BASE;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/touch_panel_scan_unit.sv]
// touch_panel_scan_unit: top level of the touch panel scan unit
// control stage, scaling stage, page memory and output register; uses tpsu_pkg
//
//  channel  handshake            fields
//  in       in_valid/in_stall    func reg_offset write_data pen_down pen_x pen_y
//  out      out_valid/out_stall  read_data irq
//
// a result passes stage one, then the output register; one word a cycle unless stalled
// the rate is set by the state update in the control stage
// reset zeroes valid and page valid bits and state but scan/settle, no clearing pass
// a stalled result holds in the output register while one further word waits

module touch_panel_scan_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [6:0]  reg_offset,
    input  logic [15:0] write_data,
    input  logic        pen_down,
    input  logic [9:0]  pen_x,
    input  logic [9:0]  pen_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        irq
);

    tpsu_pkg::s1_t s1_reg;
    logic          v1_reg;
    logic          v1_next;
    logic          accept;
    logic          out_adv;
    logic          s1_move;
    logic [tpsu_pkg::ROW_W-1:0] row;
    logic [tpsu_pkg::ROW_W-1:0] ram_q;
    logic [tpsu_pkg::ROW_W-1:0] fwd_row_reg;
    logic [tpsu_pkg::ROW_W-1:0] sel_row;
    logic          fwd_reg;
    logic          ov_reg;
    logic          ov_next;
    tpsu_pkg::rd_kind_t kind_reg;
    logic [15:0]   word_reg;
    logic [1:0]    k_reg;
    logic          irq_reg;

    assign out_adv  = !ov_reg || !out_stall;
    assign s1_move  = v1_reg && out_adv;
    assign in_stall = v1_reg && !out_adv;
    assign accept   = in_valid && !in_stall;
    assign v1_next  = accept || (v1_reg && !out_adv);
    assign ov_next  = s1_move || (ov_reg && out_stall);

    tpsu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (func),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .pen_down   (pen_down),
        .pen_x      (pen_x),
        .pen_y      (pen_y),
        .s1_reg     (s1_reg)
    );

    tpsu_scale u_scale (
        .ny  (s1_reg.ny),
        .nx  (s1_reg.nx),
        .row (row)
    );

    tpsu_page_ram u_ram (
        .clk   (clk),
        .we    (s1_move && s1_reg.wr_en),
        .waddr (s1_reg.wr_pg),
        .wdata (row),
        .re    (s1_move),
        .raddr (s1_reg.pg),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            kind_reg    <= s1_reg.kind;
            word_reg    <= s1_reg.word;
            k_reg       <= s1_reg.k;
            irq_reg     <= s1_reg.irq;
            fwd_reg     <= s1_reg.wr_en && (s1_reg.wr_pg == s1_reg.pg);
            fwd_row_reg <= row;
        end
    end

    assign sel_row   = fwd_reg ? fwd_row_reg : ram_q;
    assign read_data = (kind_reg == tpsu_pkg::RK_PAGE) ? sel_row[16*k_reg +: 16] : word_reg;
    assign irq       = irq_reg;
    assign out_valid = ov_reg;

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && ov_reg))
        else $error("input stalled with an empty stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_stall && !v1_reg) |=> !ov_reg)
        else $error("result repeated after delivery");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !out_adv) |=> (v1_reg && $stable(s1_reg)))
        else $error("stage word lost under stall");

endmodule

[hw/rtl/tpsu_page_ram.sv]
// tpsu_page_ram: two-row coordinate page memory, one row per page
// registered read, one write port; uses tpsu_pkg

module tpsu_page_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic                       waddr,
    input  logic [tpsu_pkg::ROW_W-1:0] wdata,
    input  logic                       re,
    input  logic                       raddr,
    output logic [tpsu_pkg::ROW_W-1:0] rdata
);

    logic [tpsu_pkg::ROW_W-1:0] mem [2];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[hw/rtl/tpsu_scale.sv]
// tpsu_scale: maps the scaled pen products onto the four adc words of a page row
// reciprocal multiply per axis; uses tpsu_pkg

module tpsu_scale (
    input  logic [tpsu_pkg::PROD_W-1:0] ny,
    input  logic [tpsu_pkg::PROD_W-1:0] nx,
    output logic [tpsu_pkg::ROW_W-1:0]  row
);

    logic [tpsu_pkg::PROD_W+tpsu_pkg::REC_W-1:0] py;
    logic [tpsu_pkg::PROD_W+tpsu_pkg::REC_W-1:0] px;
    logic [15:0] qy;
    logic [15:0] qx;

    assign py = (tpsu_pkg::PROD_W+tpsu_pkg::REC_W)'(ny) * tpsu_pkg::REC_Y;
    assign px = (tpsu_pkg::PROD_W+tpsu_pkg::REC_W)'(nx) * tpsu_pkg::REC_X;
    assign qy = 16'(py[tpsu_pkg::REC_SHIFT +: tpsu_pkg::QUOT_W]);
    assign qx = 16'(px[tpsu_pkg::REC_SHIFT +: tpsu_pkg::QUOT_W]);

    // word k sits at bits 16k+15:16k
    assign row = {tpsu_pkg::XP_BASE + qx, tpsu_pkg::XM_BASE - qx,
                  tpsu_pkg::YM_BASE - qy, tpsu_pkg::YP_BASE + qy};

endmodule

[hw/rtl/tpsu_ctrl.sv]
// tpsu_ctrl: register file, scan sequencer and pen-change logic of the scan unit
// produces the stage-one word per accepted item; uses tpsu_pkg

module tpsu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           func,
    input  logic [6:0]           reg_offset,
    input  logic [15:0]          write_data,
    input  logic                 pen_down,
    input  logic [9:0]           pen_x,
    input  logic [9:0]           pen_y,
    output tpsu_pkg::s1_t        s1_reg
);

    tpsu_pkg::st_t st_reg;
    tpsu_pkg::st_t st_next;
    tpsu_pkg::s1_t s1_next;
    logic [15:0]   spare_reg [3];
    logic [15:0]   spare_next [3];
    logic          reg_hit;
    logic          page_hit;
    logic [2:0]    idx;
    logic [1:0]    spare_idx;
    logic          pen_bit;
    logic [9:0]    cx;
    logic [9:0]    cy;

    assign idx       = reg_offset[4:2];
    assign spare_idx = 2'(idx - 3'd4);
    assign reg_hit   = (reg_offset <= 7'h18) && (reg_offset[1:0] == 2'd0);
    assign page_hit  = ((reg_offset >= 7'h20) && (reg_offset <= 7'h2C)) ||
                       ((reg_offset >= 7'h50) && (reg_offset <= 7'h5C));
    assign cx = (pen_x >= tpsu_pkg::X_MAX) ? tpsu_pkg::X_MAX : pen_x;
    assign cy = (pen_y >= tpsu_pkg::Y_MAX) ? tpsu_pkg::Y_MAX : pen_y;

    always_comb
    begin
        st_next = st_reg;
        st_next.smp = 1'b0;
        st_next.smp_pg = 1'b0;
        spare_next = spare_reg;
        pen_bit = 1'b0;
        s1_next.kind = tpsu_pkg::RK_WORD;
        s1_next.word = '0;
        s1_next.k = reg_offset[3:2];
        s1_next.pg = reg_offset[6];
        s1_next.ny = tpsu_pkg::PROD_W'(cy) * tpsu_pkg::PROD_W'(tpsu_pkg::Y_SPAN);
        s1_next.nx = tpsu_pkg::PROD_W'(cx) * tpsu_pkg::PROD_W'(tpsu_pkg::X_SPAN);
        unique case (tpsu_pkg::func_t'(func))
            tpsu_pkg::FUNC_TICK:
            begin
                if (st_next.cnt != '0)
                    st_next.cnt = st_next.cnt - 1'b1;
                st_next.prev = pen_down;
                if (st_reg.ss == tpsu_pkg::SS_WAIT && pen_down && !st_reg.prev)
                    st_next = tpsu_pkg::pen_went_down(st_next);
                else if (!pen_down && st_reg.prev)
                    st_next = tpsu_pkg::pen_went_up(st_next);
                else if (pen_down)
                    st_next = tpsu_pkg::take_sample(st_next, pen_down);
            end
            tpsu_pkg::FUNC_WRITE:
            begin
                if (reg_hit)
                begin
                    unique case (idx)
                        tpsu_pkg::REG_CTRL:
                        begin
                            st_next.cw = write_data[9:0] & tpsu_pkg::CTRL_WMASK;
                            st_next = tpsu_pkg::control_written(st_next, pen_down);
                        end
                        tpsu_pkg::REG_INTR:
                            st_next = tpsu_pkg::interrupt_written(st_next, write_data,
                                                                  pen_down);
                        tpsu_pkg::REG_SCAN:   st_next.siw = write_data;
                        tpsu_pkg::REG_SETTLE: st_next.stw = write_data;
                        default:              spare_next[spare_idx] = write_data;
                    endcase
                end
            end
            tpsu_pkg::FUNC_READ:
            begin
                if (reg_hit || page_hit)
                    st_next = tpsu_pkg::take_sample(st_next, pen_down);
                pen_bit = st_next.iw[0] ? st_next.lat : pen_down;
                if (reg_hit)
                begin
                    unique case (idx)
                        tpsu_pkg::REG_CTRL:
                            s1_next.word = {2'b00, pen_bit, st_next.ss, st_next.cw};
                        tpsu_pkg::REG_INTR:   s1_next.word = st_next.iw;
                        tpsu_pkg::REG_SCAN:   s1_next.word = st_next.siw;
                        tpsu_pkg::REG_SETTLE: s1_next.word = st_next.stw;
                        default:              s1_next.word = spare_reg[spare_idx];
                    endcase
                end
                else if (page_hit && reg_offset[1:0] == 2'd0)
                begin
                    if (st_next.pv[reg_offset[6]])
                        s1_next.kind = tpsu_pkg::RK_PAGE;
                    else
                        s1_next.word = tpsu_pkg::page_default(reg_offset[3:2]);
                end
            end
            default:
            begin
            end
        endcase
        s1_next.irq = |(st_next.iw[7:0] & st_next.iw[15:8]);
        s1_next.wr_en = st_next.smp;
        s1_next.wr_pg = st_next.smp_pg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            st_reg.siw <= 16'd1500;
            st_reg.stw <= 16'd200;
            spare_reg[0] <= '0;
            spare_reg[1] <= '0;
            spare_reg[2] <= '0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
            spare_reg <= spare_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

endmodule
